### hdl/dlmm_pkg.sv
// Shared types and constants of the DNA line motif matcher.
package dlmm_pkg;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_T       = 8'h54;

    localparam logic [1:0] SYM_A = 2'd0;
    localparam logic [1:0] SYM_C = 2'd1;
    localparam logic [1:0] SYM_G = 2'd2;
    localparam logic [1:0] SYM_T = 2'd3;

    localparam logic [1:0] CFG_MOTIF_CODE   = 2'd0;
    localparam logic [1:0] CFG_MOTIF_LENGTH = 2'd1;
    localparam logic [1:0] CFG_MOTIF_BAD    = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic       is_end;
        logic       sym_ok;
        logic [1:0] sym_code;
    } sym_item_t;

endpackage

### hdl/dna_line_motif_matcher_top.sv
// Top level of the DNA line motif matcher: configuration registers and part wiring.
//
// The block takes one text byte or line-end marker per cycle and gives one result per
// line end. When nothing is queued ahead of the marker, it moves from the queue into
// the result register, which holds its result until it is transferred. A classifier
// folds case and codes each byte, a four-entry queue holds the coded items,
// and the matcher shifts each symbol into its window and does the masked motif compare
// in the same cycle, so the sustained rate is one item per cycle. The matcher holds back
// a line end only while its result register is full and stalled; the input stalls only
// when the queue is full. Configuration must be written while no line is in flight.
module dna_line_motif_matcher_top
    import dlmm_pkg::*;
#(
    parameter int MAX_MOTIF       = 32,
    parameter int LINE_COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        is_line_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] line_index,
    output logic        line_valid,
    output logic        motif_found,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] motif_code_reg;
    logic [5:0]  motif_length_reg;
    logic        motif_bad_reg;

    sym_item_t   front_item;
    sym_item_t   head_item;
    logic        queue_full;
    logic        queue_not_empty;
    logic        queue_pop;
    logic        in_push;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;
    assign in_push   = in_valid && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_code_reg   <= '0;
            motif_length_reg <= '0;
            motif_bad_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MOTIF_CODE:   motif_code_reg   <= cfg_data;
                CFG_MOTIF_LENGTH: motif_length_reg <= cfg_data[5:0];
                CFG_MOTIF_BAD:    motif_bad_reg    <= cfg_data[0];
                default:          motif_bad_reg    <= motif_bad_reg;
            endcase
        end
    end

    dlmm_front u_front
    (
        .text_byte   (text_byte),
        .is_line_end (is_line_end),
        .item        (front_item)
    );

    dlmm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_push),
        .push_item (front_item),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    dlmm_back #(
        .MAX_MOTIF       (MAX_MOTIF),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_ready   (queue_not_empty),
        .item         (head_item),
        .pop          (queue_pop),
        .motif_code   (motif_code_reg),
        .motif_length (motif_length_reg),
        .motif_bad    (motif_bad_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_index   (line_index),
        .line_valid   (line_valid),
        .motif_found  (motif_found)
    );

endmodule

### hdl/dlmm_front.sv
// Front end: folds case and classifies each accepted byte into a symbol item.
module dlmm_front
    import dlmm_pkg::*;
(
    input  logic      [7:0] text_byte,
    input  logic            is_line_end,
    output sym_item_t       item
);

    logic [7:0] folded;

    always_comb
    begin
        folded = text_byte;
        if (text_byte >= CHAR_LOWER_A && text_byte <= CHAR_LOWER_Z)
        begin
            folded = text_byte - CASE_OFFSET;
        end
        item.is_end   = is_line_end;
        item.sym_ok   = 1'b1;
        item.sym_code = SYM_A;
        unique case (folded)
            CHAR_A: item.sym_code = SYM_A;
            CHAR_C: item.sym_code = SYM_C;
            CHAR_G: item.sym_code = SYM_G;
            CHAR_T: item.sym_code = SYM_T;
            default: item.sym_ok = 1'b0;
        endcase
    end

endmodule

### hdl/dlmm_queue.sv
// Short queue of classified items between the front end and the matcher.
module dlmm_queue
    import dlmm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sym_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output sym_item_t head_item
);

    sym_item_t                entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/dlmm_back.sv
// Back end: sliding symbol window, motif compare, line counter and result register.
module dlmm_back
    import dlmm_pkg::*;
#(
    parameter int MAX_MOTIF       = 32,
    parameter int LINE_COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_ready,
    input  sym_item_t   item,
    output logic        pop,
    input  logic [63:0] motif_code,
    input  logic [5:0]  motif_length,
    input  logic        motif_bad,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] line_index,
    output logic        line_valid,
    output logic        motif_found
);

    localparam int WIN_W  = 2 * MAX_MOTIF;
    localparam int SEEN_W = $clog2(MAX_MOTIF + 1);

    logic [WIN_W-1:0]           win_reg;
    logic [WIN_W-1:0]           win_next;
    logic [SEEN_W-1:0]          seen_reg;
    logic [SEEN_W-1:0]          seen_next;
    logic                       ok_reg;
    logic                       ok_next;
    logic                       match_reg;
    logic                       match_next;
    logic [LINE_COUNT_BITS-1:0] count_reg;
    logic [LINE_COUNT_BITS-1:0] count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [15:0]                index_reg;
    logic [15:0]                index_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       found_reg;
    logic                       found_next;

    logic                       out_free;
    logic                       len_fits;
    logic [6:0]                 align_shift;
    logic [WIN_W-1:0]           aligned_motif;
    logic [WIN_W-1:0]           motif_mask;
    logic [WIN_W-1:0]           shifted_win;
    logic [SEEN_W-1:0]          inc_seen;
    logic                       match_now;
    logic [32:0]                count_ext;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = item_ready && (!item.is_end || out_free);

    assign len_fits      = (motif_length != '0) && (7'(motif_length) <= 7'(MAX_MOTIF));
    assign align_shift   = 7'(WIN_W) - {motif_length, 1'b0};
    assign aligned_motif = motif_code[WIN_W-1:0] << align_shift;
    assign motif_mask    = {WIN_W{1'b1}} << align_shift;

    assign shifted_win = {item.sym_code, win_reg[WIN_W-1:2]};
    assign inc_seen    = (seen_reg == SEEN_W'(MAX_MOTIF)) ? seen_reg : seen_reg + 1'b1;
    assign match_now   = len_fits && !motif_bad && (7'(inc_seen) >= 7'(motif_length))
                         && (((shifted_win ^ aligned_motif) & motif_mask) == '0);
    assign count_ext   = 33'(count_reg);

    always_comb
    begin
        win_next       = win_reg;
        seen_next      = seen_reg;
        ok_next        = ok_reg;
        match_next     = match_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        index_next     = index_reg;
        valid_next     = valid_reg;
        found_next     = found_reg;
        if (pop)
        begin
            if (item.is_end)
            begin
                out_valid_next = 1'b1;
                index_next     = (count_ext > 33'h0FFFF) ? 16'hFFFF : count_ext[15:0];
                valid_next     = ok_reg;
                found_next     = !motif_bad && ok_reg
                                 && ((motif_length == '0) || match_reg);
                if (ok_reg && (count_reg != {LINE_COUNT_BITS{1'b1}}))
                begin
                    count_next = count_reg + 1'b1;
                end
                win_next   = '0;
                seen_next  = '0;
                ok_next    = 1'b1;
                match_next = 1'b0;
            end
            else if (!item.sym_ok)
            begin
                ok_next = 1'b0;
            end
            else
            begin
                win_next  = shifted_win;
                seen_next = inc_seen;
                if (match_now)
                begin
                    match_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            seen_reg      <= '0;
            ok_reg        <= 1'b1;
            match_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            seen_reg      <= seen_next;
            ok_reg        <= ok_next;
            match_reg     <= match_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
        valid_reg <= valid_next;
        found_reg <= found_next;
    end

    assign out_valid   = out_valid_reg;
    assign line_index  = index_reg;
    assign line_valid  = valid_reg;
    assign motif_found = found_reg;

endmodule

### dv/dna_line_motif_matcher_top_tb.sv
`timescale 1ns / 100ps
// Testbench for the DNA line motif matcher: random text lines checked against a line predictor.

typedef struct {
    logic [15:0] line_index;
    logic        line_valid;
    logic        motif_found;
} line_report_t;

class motif_line_tracker;
    localparam int MAX_SYMBOLS = 32;

    logic [63:0]  motif_code;
    logic [5:0]   motif_len;
    logic         motif_bad;
    logic [63:0]  window;
    logic [5:0]   seen;
    logic         line_ok;
    logic         hit;
    logic [15:0]  valid_count;
    line_report_t expected_reports[$];
    int           errors;
    int           reports_checked;
    int           valid_reports;
    int           found_reports;
    int           items_taken;
    int           writes_taken;

    function new();
        motif_code      = '0;
        motif_len       = '0;
        motif_bad       = 1'b0;
        valid_count     = '0;
        errors          = 0;
        reports_checked = 0;
        valid_reports   = 0;
        found_reports   = 0;
        items_taken     = 0;
        writes_taken    = 0;
        clear_line();
    endfunction

    function void clear_line();
        window  = '0;
        seen    = '0;
        line_ok = 1'b1;
        hit     = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
        writes_taken++;
        case (idx)
            dlmm_pkg::CFG_MOTIF_CODE:   motif_code = data;
            dlmm_pkg::CFG_MOTIF_LENGTH: motif_len  = data[5:0];
            dlmm_pkg::CFG_MOTIF_BAD:    motif_bad  = data[0];
            default: ;
        endcase
    endfunction

    // Returns {not_a_nucleotide, symbol}.
    function logic [2:0] classify(logic [7:0] ch);
        logic [7:0] up;
        up = ch;
        if (ch >= dlmm_pkg::CHAR_LOWER_A && ch <= dlmm_pkg::CHAR_LOWER_Z)
            up = ch - dlmm_pkg::CASE_OFFSET;
        case (up)
            dlmm_pkg::CHAR_A: return {1'b0, dlmm_pkg::SYM_A};
            dlmm_pkg::CHAR_C: return {1'b0, dlmm_pkg::SYM_C};
            dlmm_pkg::CHAR_G: return {1'b0, dlmm_pkg::SYM_G};
            dlmm_pkg::CHAR_T: return {1'b0, dlmm_pkg::SYM_T};
            default:          return 3'b100;
        endcase
    endfunction

    function logic window_hit();
        int          n;
        logic [63:0] mask;
        n = motif_len;
        if (motif_bad || n == 0 || n > MAX_SYMBOLS || seen < n)
            return 1'b0;
        mask = (n == 32) ? '1 : ((64'd1 << (2 * n)) - 64'd1);
        return (window >> (64 - 2 * n)) == (motif_code & mask);
    endfunction

    function void take_item(logic [7:0] ch, logic last);
        logic [2:0]   sym;
        line_report_t rep;
        items_taken++;
        if (!last)
        begin
            sym = classify(ch);
            if (sym[2])
            begin
                line_ok = 1'b0;
            end
            else
            begin
                window = {sym[1:0], window[63:2]};
                if (seen < MAX_SYMBOLS)
                    seen++;
                if (window_hit())
                    hit = 1'b1;
            end
        end
        else
        begin
            rep.line_index  = valid_count;
            rep.line_valid  = line_ok;
            if (motif_bad)
                rep.motif_found = 1'b0;
            else if (motif_len == 0)
                rep.motif_found = line_ok;
            else
                rep.motif_found = line_ok && hit;
            expected_reports.insert(expected_reports.size(), rep);
            if (line_ok && valid_count != 16'hFFFF)
                valid_count++;
            clear_line();
        end
    endfunction

    function void check_report(logic [15:0] idx, logic v, logic f);
        line_report_t want;
        reports_checked++;
        valid_reports += v;
        found_reports += f;
        if (expected_reports.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected line report index=%0d valid=%0b found=%0b",
                         idx, v, f);
        end
        else
        begin
            want = expected_reports.pop_front();
            if (want.line_index !== idx || want.line_valid !== v
                || want.motif_found !== f)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: line report %0d: expected index=%0d valid=%0b found=%0b,",
                             reports_checked, want.line_index, want.line_valid,
                             want.motif_found,
                             " got index=%0d valid=%0b found=%0b", idx, v, f);
            end
        end
    endfunction
endclass

module dna_line_motif_matcher_top_tb;
    import dlmm_pkg::*;

    localparam int          STALL_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          PHASE_ITEMS  = 160;
    localparam int          NUM_PHASES   = 10;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  text_byte;
    logic        is_line_end;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] line_index;
    logic        line_valid;
    logic        motif_found;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    motif_line_tracker tracker;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int items_in_phase;

    dna_line_motif_matcher_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .is_line_end (is_line_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_index  (line_index),
        .line_valid  (line_valid),
        .motif_found (motif_found),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_report(line_index, line_valid, motif_found);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [7:0] nucleotide_char(logic [1:0] s);
        logic [7:0] c;
        case (s)
            SYM_A:   c = CHAR_A;
            SYM_C:   c = CHAR_C;
            SYM_G:   c = CHAR_G;
            default: c = CHAR_T;
        endcase
        if ($urandom_range(1))
            c = c | CASE_OFFSET;
        return c;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic set_motif(input logic [63:0] code, input logic [5:0] n, input logic bad);
        logic [63:0] word;
        write_reg(CFG_MOTIF_CODE, code);
        word = {$urandom, $urandom};
        word[5:0] = n;
        write_reg(CFG_MOTIF_LENGTH, word);
        word = {$urandom, $urandom};
        word[0] = bad;
        write_reg(CFG_MOTIF_BAD, word);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            text_byte <= 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        is_line_end <= last;
        do @(posedge clk); while (in_stall);
        tracker.take_item(b, last);
        items_in_phase++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.expected_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_line();
        logic [7:0] chars[$];
        int         len;
        int         kind;
        int         pos;
        int         n;
        kind = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(12);
        for (int i = 0; i < len; i++)
            chars.insert(chars.size(), nucleotide_char(2'($urandom_range(3))));
        n = tracker.motif_len;
        if (kind < 45 && n >= 1 && n <= 32)
        begin
            pos = $urandom_range(len);
            for (int i = 0; i < n; i++)
                chars.insert(pos + i, nucleotide_char(tracker.motif_code[2 * i +: 2]));
        end
        if (kind >= 70 && kind < 88)
            chars.insert($urandom_range(chars.size()), 8'($urandom_range(255)));
        if (kind >= 88)
        begin
            for (int i = 0; i < chars.size(); i++)
                chars[i] = 8'($urandom_range(255));
        end
        foreach (chars[i])
            send_item(chars[i], 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic config_phase(input int p);
        logic [63:0] code;
        logic [5:0]  n;
        logic        bad;
        code = {$urandom, $urandom};
        bad  = 1'b0;
        case (p)
            0: n = 6'd0;
            1:
            begin
                n    = 6'd32;
                code = '1;
            end
            2:
            begin
                n    = 6'd1;
                code = '0;
            end
            3: n = 6'd63;
            4:
            begin
                n   = 6'd3;
                bad = 1'b1;
            end
            5: n = 6'd32;
            6:
            begin
                n   = 6'd0;
                bad = 1'b1;
            end
            7:
            begin
                n    = 6'($urandom_range(8, 2));
                code = '0;
            end
            default: n = 6'($urandom_range(10, 1));
        endcase
        set_motif(code, n, bad);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 72;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 72;
            end
            default:
            begin
                send_idle_pct  = 14;
                recv_stall_pct = 14;
            end
        endcase
    endtask

    initial
    begin
        tracker        = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        text_byte      = '0;
        is_line_end    = 1'b0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_MOTIF_CODE;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        items_in_phase = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset motif is empty, so every valid line matches.
        send_item(8'hFF, 1'b1);
        send_item(CHAR_A | CASE_OFFSET, 1'b0);
        send_item(CHAR_C | CASE_OFFSET, 1'b0);
        send_item(CHAR_G | CASE_OFFSET, 1'b0);
        send_item(CHAR_T | CASE_OFFSET, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(CHAR_A, 1'b0);
        send_item(CHAR_C, 1'b0);
        send_item(CHAR_G, 1'b0);
        send_item(CHAR_T, 1'b0);
        send_item(8'h5A, 1'b1);
        send_item(8'h80, 1'b0);
        send_item(8'hAA, 1'b1);
        send_item(CHAR_A, 1'b0);
        send_item(8'h0D, 1'b0);
        send_item(8'h55, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b1);
        settle();
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        @(negedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_idling(p % 4);
            config_phase(p);
            items_in_phase = 0;
            while (items_in_phase < PHASE_ITEMS)
                send_line();
            settle();
        end

        set_idling(3);
        set_motif({$urandom, $urandom}, 6'($urandom_range(4, 1)), 1'b0);
        items_in_phase = 0;
        while (items_in_phase < 60)
            send_line();
        settle();

        $display("Run covered %0d input transfers and %0d register writes over %0d phases.",
                 tracker.items_taken, tracker.writes_taken, NUM_PHASES + 1);
        $display("Line reports checked: %0d, valid lines %0d, motif hits %0d, errors %0d.",
                 tracker.reports_checked, tracker.valid_reports, tracker.found_reports,
                 tracker.errors);
        if (tracker.errors == 0 && tracker.expected_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### filelist.f
hdl/dlmm_pkg.sv
hdl/dlmm_front.sv
hdl/dlmm_queue.sv
hdl/dlmm_back.sv
hdl/dna_line_motif_matcher_top.sv
dv/dna_line_motif_matcher_top_tb.sv
